### rtl/adl_pkg.sv
// Shared constants and types for the Adler-32 checksum engine.
`default_nettype none

package adl_pkg;

	// Adler-32 modulus and datapath sizes
	localparam int unsigned ADLER_MOD     = 65521;
	localparam int unsigned DATA_LANES    = 4;
	localparam int unsigned LANES_DEFAULT = 4;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned SUM_W         = 16;
	localparam int unsigned CNT_W         = 3;
	localparam int unsigned WGT_W         = 3;
	// up to four bytes of 255
	localparam int unsigned PLAIN_SUM_W   = 10;
	// up to (4+3+2+1) * 255
	localparam int unsigned WGT_SUM_W     = 12;
	localparam int unsigned LANE_TERM_W   = 10;

	// What one byte lane contributes to the low and high sums
	typedef struct packed {
		logic [BYTE_W-1:0]      plain;
		logic [LANE_TERM_W-1:0] weighted;
	} lane_term_t;

	// Merged lane results for one transaction, handed to the accumulator
	typedef struct packed {
		logic                   start;
		logic                   last;
		logic [CNT_W-1:0]       cnt;
		logic [PLAIN_SUM_W-1:0] plain_sum;
		logic [WGT_SUM_W-1:0]   wgt_sum;
	} stage_item_t;

endpackage

`default_nettype wire

### rtl/adler32_checksum_engine.sv
// Adler-32 checksum engine top level: lane stage, accumulator and output skid.
//
// Input channel (in_valid / in_stall): one transaction carries up to four
// bytes in data_bytes, lane 0 in bits 7:0, with byte_count valid lanes
// (clamped to the lane count). start_req restarts the sums at low=1, high=0
// before the bytes; last asks for a checksum after them.
// Output channel (out_valid / out_stall): one checksum, high sum in 31:16 and
// low sum in 15:0, for each transaction that had last set.
// Throughput: one transaction per cycle while in_stall is low. The byte lanes
// are summed in the first stage; the accumulator folds a whole transaction
// into the sums at once, which is the only loop in the design.
// Path: a transaction is registered in the input stage, and its checksum in
// the output register, or in the skid entry while the output register is held.
// Reset: asynchronous, active low; sums return to low=1, high=0, output empty.
// Receiver stall: checksums park in the output register and one skid entry;
// in_stall rises only when both are full and a last transaction waits.
`default_nettype none

module adler32_checksum_engine #(
	parameter int unsigned LANES = adl_pkg::LANES_DEFAULT
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           in_valid,
	output logic                                                in_stall,
	input  wire logic                                           start_req,
	input  wire logic [adl_pkg::DATA_LANES*adl_pkg::BYTE_W-1:0] data_bytes,
	input  wire logic [adl_pkg::CNT_W-1:0]                      byte_count,
	input  wire logic                                           last,
	output logic                                                out_valid,
	input  wire logic                                           out_stall,
	output logic [2*adl_pkg::SUM_W-1:0]                         checksum
);
	import adl_pkg::*;

	logic                 advance;
	logic                 item_valid;
	stage_item_t          item;
	logic                 update;
	logic                 push;
	logic                 out_free;
	logic [2*SUM_W-1:0]   sum_next;
	logic                 out_valid_q;
	logic                 skid_valid_q;
	logic [2*SUM_W-1:0]   out_q;
	logic [2*SUM_W-1:0]   skid_q;

	// Stall only when a checksum must be pushed and both output slots are full
	assign in_stall = item_valid && item.last && skid_valid_q;
	assign advance  = !in_stall;
	assign update   = item_valid && advance;
	assign push     = update && item.last;
	assign out_free = !out_valid_q || !out_stall;

	adl_merge #(
		.LANES(LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (in_valid),
		.start_req (start_req),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.last      (last),
		.item_valid(item_valid),
		.item      (item)
	);

	adl_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (update),
		.item    (item),
		.sum_next(sum_next)
	);

	// Output register and skid entry: track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid entry: move the checksums
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= sum_next;
				end
			end else if (push) begin
				out_q <= sum_next;
			end
		end else if (push) begin
			skid_q <= sum_next;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = out_q;

`ifndef ASSERT_OFF
	// A checksum is never pushed over a full skid entry
	a_no_skid_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("checksum pushed while skid entry full");

	// The skid entry fills only behind a held output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// Both sums leave fully reduced
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (checksum[SUM_W-1:0] < SUM_W'(ADLER_MOD))
			&& (checksum[2*SUM_W-1:SUM_W] < SUM_W'(ADLER_MOD)))
		else $error("checksum sum not reduced");
`endif

endmodule

`default_nettype wire

### rtl/adl_lane.sv
// One byte lane: masks the byte by the count and weights it for the high sum.
`default_nettype none

module adl_lane #(
	parameter int unsigned LANE_IDX = 0
) (
	input  wire logic [adl_pkg::BYTE_W-1:0] byte_in,
	input  wire logic [adl_pkg::CNT_W-1:0]  cnt,
	output adl_pkg::lane_term_t             term
);
	import adl_pkg::*;

	logic             in_use;
	logic [WGT_W-1:0] weight;

	// A byte at lane i is added into the high sum (cnt - i) times
	assign in_use = (cnt > CNT_W'(LANE_IDX));
	assign weight = WGT_W'(cnt - CNT_W'(LANE_IDX));

	always_comb begin
		if (in_use) begin
			term.plain    = byte_in;
			term.weighted = LANE_TERM_W'(LANE_TERM_W'(byte_in) * LANE_TERM_W'(weight));
		end else begin
			term.plain    = '0;
			term.weighted = '0;
		end
	end

endmodule

`default_nettype wire

### rtl/adl_merge.sv
// Input stage: byte lanes side by side, lane results summed and registered.
`default_nettype none

module adl_merge #(
	parameter int unsigned LANES = adl_pkg::LANES_DEFAULT
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      advance,
	input  wire logic                                      in_valid,
	input  wire logic                                      start_req,
	input  wire logic [adl_pkg::DATA_LANES*adl_pkg::BYTE_W-1:0] data_bytes,
	input  wire logic [adl_pkg::CNT_W-1:0]                 byte_count,
	input  wire logic                                      last,
	output logic                                           item_valid,
	output adl_pkg::stage_item_t                           item
);
	import adl_pkg::*;

	localparam int unsigned ACT_LANES = (LANES < DATA_LANES) ? LANES : DATA_LANES;

	logic [CNT_W-1:0]       cnt_sat;
	lane_term_t             terms [ACT_LANES];
	logic [PLAIN_SUM_W-1:0] plain_sum;
	logic [WGT_SUM_W-1:0]   wgt_sum;
	logic                   valid_s1;
	stage_item_t            item_s1;

	// Clamp the count to the lanes that exist
	assign cnt_sat = (byte_count > CNT_W'(ACT_LANES)) ? CNT_W'(ACT_LANES) : byte_count;

	// Instantiate the byte lanes
	for (genvar i = 0; i < ACT_LANES; i++) begin : g_lane
		adl_lane #(
			.LANE_IDX(i)
		) u_lane (
			.byte_in(data_bytes[BYTE_W*i +: BYTE_W]),
			.cnt    (cnt_sat),
			.term   (terms[i])
		);
	end

	// Merge what the lanes found
	always_comb begin
		plain_sum = '0;
		wgt_sum   = '0;
		for (int i = 0; i < ACT_LANES; i++) begin
			plain_sum = plain_sum + PLAIN_SUM_W'(terms[i].plain);
			wgt_sum   = wgt_sum + WGT_SUM_W'(terms[i].weighted);
		end
	end

	// Advance the stage valid unless the output side holds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the merged transaction
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1.start     <= start_req;
			item_s1.last      <= last;
			item_s1.cnt       <= cnt_sat;
			item_s1.plain_sum <= plain_sum;
			item_s1.wgt_sum   <= wgt_sum;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

`default_nettype wire

### rtl/adl_accum.sv
// Running sums: on update, folds one transaction per cycle into low and high sums.
`default_nettype none

module adl_accum (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     update,
	input  wire adl_pkg::stage_item_t     item,
	output logic [2*adl_pkg::SUM_W-1:0]   sum_next
);
	import adl_pkg::*;

	localparam int unsigned HIGH_W    = SUM_W + 4;
	localparam int unsigned RED_STEPS = DATA_LANES + 1;

	logic [SUM_W-1:0]  low_q;
	logic [SUM_W-1:0]  high_q;
	logic [SUM_W-1:0]  base_low;
	logic [SUM_W-1:0]  base_high;
	logic [SUM_W:0]    low_raw;
	logic [SUM_W-1:0]  low_new;
	logic [HIGH_W-1:0] high_raw;
	logic [SUM_W-1:0]  high_new;

	// Start from the initial value on a start request
	assign base_low  = item.start ? SUM_W'(1) : low_q;
	assign base_high = item.start ? '0 : high_q;

	// Low sum grows by less than the modulus: one conditional subtract
	assign low_raw = (SUM_W+1)'(base_low) + (SUM_W+1)'(item.plain_sum);
	assign low_new = (low_raw >= (SUM_W+1)'(ADLER_MOD))
		? SUM_W'(low_raw - (SUM_W+1)'(ADLER_MOD)) : low_raw[SUM_W-1:0];

	// High sum gains cnt copies of the old low sum plus the weighted bytes
	assign high_raw = HIGH_W'(base_high)
		+ HIGH_W'(HIGH_W'(base_low) * HIGH_W'(item.cnt))
		+ HIGH_W'(item.wgt_sum);

	// Reduce: compare against each multiple of the modulus in parallel
	always_comb begin
		high_new = high_raw[SUM_W-1:0];
		for (int k = 1; k <= RED_STEPS; k++) begin
			if (high_raw >= HIGH_W'(k * ADLER_MOD)) begin
				high_new = SUM_W'(high_raw - HIGH_W'(k * ADLER_MOD));
			end
		end
	end

	assign sum_next = {high_new, low_new};

	// Hold the sums between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= SUM_W'(1);
			high_q <= '0;
		end else if (update) begin
			low_q  <= low_new;
			high_q <= high_new;
		end
	end

endmodule

`default_nettype wire
